### sv/stl_pkg.sv
// Shared types, token codes and character helpers for the source token lexer.
package stl_pkg;

  localparam int OffsetBitsDef = 16;
  localparam int LenW          = 16;
  localparam int ResMax        = 3;
  localparam int QueueDepth    = 8;

  typedef enum logic [2:0] {
    ModeIdle   = 3'd0,
    ModeWord   = 3'd1,
    ModeMinus  = 3'd2,
    ModeNumber = 3'd3,
    ModeQuote1 = 3'd4,
    ModeQuote2 = 3'd5,
    ModeBang   = 3'd6,
    ModeEq     = 3'd7
  } mode_e;

  typedef enum logic [4:0] {
    KindReturn  = 5'd0,
    KindIf      = 5'd1,
    KindElse    = 5'd2,
    KindWhile   = 5'd3,
    KindFor     = 5'd4,
    KindVoid    = 5'd5,
    KindNull    = 5'd6,
    KindSymbol  = 5'd7,
    KindInt     = 5'd8,
    KindFloat   = 5'd9,
    KindChar    = 5'd10,
    KindLParen  = 5'd11,
    KindRParen  = 5'd12,
    KindLBrace  = 5'd13,
    KindRBrace  = 5'd14,
    KindComma   = 5'd15,
    KindDot     = 5'd16,
    KindMinus   = 5'd17,
    KindPlus    = 5'd18,
    KindSemi    = 5'd19,
    KindSlash   = 5'd20,
    KindStar    = 5'd21,
    KindBang    = 5'd22,
    KindBangEq  = 5'd23,
    KindSet     = 5'd24,
    KindEq      = 5'd25,
    KindUnknown = 5'd26,
    KindEnd     = 5'd27
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [15:0]      start;
    logic [LenW-1:0]  length;
    logic             last;
  } res_t;

  localparam int KwCount = 7;

  // Keyword text, right-justified: byte i of a keyword of length L sits at byte L-1-i.
  localparam logic [47:0] KwText [8] = '{
    48'("return"), 48'("if"), 48'("else"), 48'("while"),
    48'("for"), 48'("void"), 48'("null"), 48'd0
  };

  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChQuote = 8'h27;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChEq    = 8'h3D;

  function automatic logic [2:0] kw_len(logic [2:0] k);
    logic [2:0] l;
    case (k)
      3'd0:    l = 3'd6;
      3'd1:    l = 3'd2;
      3'd2:    l = 3'd4;
      3'd3:    l = 3'd5;
      3'd4:    l = 3'd3;
      3'd5:    l = 3'd4;
      3'd6:    l = 3'd4;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] kw_char(logic [2:0] k, logic [2:0] i);
    logic [2:0]  pos;
    logic [47:0] txt;
    pos = kw_len(k) - 3'd1 - i;
    txt = KwText[k];
    return txt[{pos, 3'b000} +: 8];
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic kind_e delim_kind(logic [7:0] c);
    kind_e k;
    case (c)
      8'h28:   k = KindLParen;
      8'h29:   k = KindRParen;
      8'h7B:   k = KindLBrace;
      8'h7D:   k = KindRBrace;
      8'h2C:   k = KindComma;
      8'h2E:   k = KindDot;
      8'h2B:   k = KindPlus;
      8'h3B:   k = KindSemi;
      8'h2F:   k = KindSlash;
      8'h2A:   k = KindStar;
      default: k = KindUnknown;
    endcase
    return k;
  endfunction

endpackage

### sv/stl_step.sv
// Per-byte scanner: holds the open token and works out up to three results per byte.
module stl_step #(
  parameter int OffsetBits = stl_pkg::OffsetBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [7:0]                            char_code_i,
  input  logic                                  end_of_text_i,
  input  logic                                  accept_i,
  output stl_pkg::res_t [stl_pkg::ResMax-1:0]   res_o,
  output logic [1:0]                            res_cnt_o
);
  import stl_pkg::*;

  mode_e                  mode_q, mode_d;
  logic [OffsetBits-1:0]  start_q, start_d;
  logic [LenW-1:0]        len_q, len_d;
  logic [KwCount-1:0]     kmask_q, kmask_d;
  logic                   dot_q, dot_d;
  logic [OffsetBits-1:0]  off_q, off_d;

  res_t [ResMax-1:0]      res;
  logic [1:0]             cnt;

  function automatic logic [KwCount-1:0] match_mask(logic [KwCount-1:0] m, logic [7:0] c,
                                                    logic [LenW-1:0] len);
    logic [KwCount-1:0] r;
    r = m;
    for (int k = 0; k < KwCount; k++) begin
      if (len >= LenW'(kw_len(3'(k))) || kw_char(3'(k), len[2:0]) != c) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [LenW-1:0] grow(logic [LenW-1:0] l);
    return (l == {LenW{1'b1}}) ? l : l + LenW'(1);
  endfunction

  function automatic kind_e flush_kind(mode_e m, logic [KwCount-1:0] km, logic [LenW-1:0] len,
                                       logic dot);
    kind_e k;
    case (m)
      ModeWord: begin
        k = KindSymbol;
        for (int i = 0; i < KwCount; i++) begin
          if (km[i] && len == LenW'(kw_len(3'(i)))) begin
            k = kind_e'(5'(i));
          end
        end
      end
      ModeMinus:  k = KindMinus;
      ModeNumber: k = dot ? KindFloat : KindInt;
      ModeBang:   k = KindBang;
      ModeEq:     k = KindSet;
      default:    k = KindUnknown;
    endcase
    return k;
  endfunction

  function automatic res_t mk(kind_e k, logic [15:0] s, logic [LenW-1:0] l, logic last);
    res_t r;
    r.kind   = k;
    r.start  = s;
    r.length = l;
    r.last   = last;
    return r;
  endfunction

  always_comb begin
    logic       go;
    logic [7:0] c;
    c       = char_code_i;
    go      = 1'b0;
    mode_d  = mode_q;
    start_d = start_q;
    len_d   = len_q;
    kmask_d = kmask_q;
    dot_d   = dot_q;
    off_d   = off_q;
    res     = '0;
    cnt     = 2'd0;

    if (c != 8'd0) begin
      case (mode_q)
        ModeWord: begin
          if (is_letter(c)) begin
            kmask_d = match_mask(kmask_q, c, len_q);
            len_d   = grow(len_q);
          end else begin
            go = 1'b1;
          end
        end
        ModeMinus: begin
          if (is_digit(c)) begin
            mode_d = ModeNumber;
            dot_d  = 1'b0;
            len_d  = grow(len_q);
          end else begin
            go = 1'b1;
          end
        end
        ModeNumber: begin
          if (c == ChDot) begin
            if (dot_q) begin
              // second dot: close the run as unknown, rescan the dot
              res[cnt] = mk(KindUnknown, 16'(start_q), len_q, 1'b0);
              cnt      = cnt + 2'd1;
              mode_d   = ModeIdle;
              go       = 1'b1;
            end else begin
              dot_d = 1'b1;
              len_d = grow(len_q);
            end
          end else if (is_letter(c) || is_digit(c)) begin
            len_d = grow(len_q);
          end else begin
            go = 1'b1;
          end
        end
        ModeQuote1: begin
          mode_d = ModeQuote2;
          len_d  = grow(len_q);
        end
        ModeQuote2: begin
          if (c == ChQuote) begin
            res[cnt] = mk(KindChar, 16'(start_q), grow(len_q), 1'b0);
            cnt      = cnt + 2'd1;
            mode_d   = ModeIdle;
          end else begin
            go = 1'b1;
          end
        end
        ModeBang, ModeEq: begin
          if (c == ChEq) begin
            res[cnt] = mk((mode_q == ModeBang) ? KindBangEq : KindEq, 16'(start_q),
                          grow(len_q), 1'b0);
            cnt      = cnt + 2'd1;
            mode_d   = ModeIdle;
          end else begin
            go = 1'b1;
          end
        end
        default: go = 1'b1;
      endcase

      // close the open token before the byte starts a new one
      if (go && mode_d != ModeIdle) begin
        res[cnt] = mk(flush_kind(mode_d, kmask_d, len_d, dot_d), 16'(start_d), len_d, 1'b0);
        cnt      = cnt + 2'd1;
      end

      if (go) begin
        mode_d = ModeIdle;
        if (is_space(c)) begin
          mode_d = ModeIdle;
        end else if (is_letter(c)) begin
          kmask_d = match_mask({KwCount{1'b1}}, c, '0);
          mode_d  = ModeWord;
          start_d = off_q;
          len_d   = LenW'(1);
        end else if (is_digit(c)) begin
          dot_d   = 1'b0;
          mode_d  = ModeNumber;
          start_d = off_q;
          len_d   = LenW'(1);
        end else if (c == ChMinus || c == ChQuote || c == ChBang || c == ChEq) begin
          start_d = off_q;
          len_d   = LenW'(1);
          case (c)
            ChMinus: mode_d = ModeMinus;
            ChQuote: mode_d = ModeQuote1;
            ChBang:  mode_d = ModeBang;
            default: mode_d = ModeEq;
          endcase
        end else begin
          res[cnt] = mk(delim_kind(c), 16'(off_q), LenW'(1), 1'b0);
          cnt      = cnt + 2'd1;
        end
      end

      off_d = off_q + OffsetBits'(1);
    end

    if (c == 8'd0 || end_of_text_i) begin
      if (mode_d != ModeIdle) begin
        res[cnt] = mk(flush_kind(mode_d, kmask_d, len_d, dot_d), 16'(start_d), len_d, 1'b0);
        cnt      = cnt + 2'd1;
      end
      res[cnt] = mk(KindEnd, 16'(off_d), '0, 1'b1);
      cnt      = cnt + 2'd1;
      mode_d   = ModeIdle;
      start_d  = '0;
      len_d    = '0;
      kmask_d  = {KwCount{1'b1}};
      dot_d    = 1'b0;
      off_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      start_q <= '0;
      len_q   <= '0;
      kmask_q <= {KwCount{1'b1}};
      dot_q   <= 1'b0;
      off_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      len_q   <= len_d;
      kmask_q <= kmask_d;
      dot_q   <= dot_d;
      off_q   <= off_d;
    end
  end

  assign res_o     = res;
  assign res_cnt_o = accept_i ? cnt : 2'd0;

endmodule

### sv/stl_queue.sv
// Result queue: takes up to three results a cycle and hands out one.
module stl_queue (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [1:0]                            push_cnt_i,
  input  stl_pkg::res_t [stl_pkg::ResMax-1:0]   push_data_i,
  input  logic                                  pop_i,
  output stl_pkg::res_t                         head_o,
  output logic                                  space_o,
  output logic                                  valid_o
);
  import stl_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = PtrW + 1;

  res_t            mem [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q + PtrW'(push_cnt_i);
    rd_d  = rd_q + PtrW'(pop_i);
    cnt_d = cnt_q + CntW'(push_cnt_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < ResMax; j++) begin
      if (2'(j) < push_cnt_i) begin
        mem[wr_q + PtrW'(j)] <= push_data_i[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = mem[rd_q];
  assign valid_o = cnt_q != '0;
  // room for a worst-case byte
  assign space_o = cnt_q <= CntW'(QueueDepth - ResMax);

endmodule

### sv/source_token_lexer.sv
// Source token lexer: bytes in, tokens (kind, start, length, last) out.
//
// Input channel: char_code_i / end_of_text_i with in_valid_i / in_ready_o.
// A byte is taken on a cycle where both valid and ready are high. A zero
// byte or end_of_text_i closes the text: the open token is flushed, an end
// token with is_last_o set follows, and offsets restart from zero.
// Output channel: token fields with out_valid_o / out_ready_i, one token
// per accepted handshake.
// Tokens a byte causes are registered into the result queue behind any
// already queued and leave its head one per cycle while out_ready_i is high.
// Throughput: one byte per cycle. A byte yields up to three tokens, which
// go into an eight-entry result queue; in_ready_o is high while the queue
// has room for three. Input stalls when the receiver holds back or when
// bytes yield more than one token a cycle on average.
// Reset: the scanner returns to idle between tokens at offset zero and the
// queue empties; no clearing pass.
// Receiver stall: queued tokens hold at the head until taken.
module source_token_lexer #(
  parameter int OffsetBits = stl_pkg::OffsetBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic        is_last_o
);
  import stl_pkg::*;

  res_t [ResMax-1:0] res;
  logic [1:0]        res_cnt;
  res_t              head;
  logic              space;
  logic              accept;

  assign accept = in_valid_i && in_ready_o;

  stl_step #(
    .OffsetBits(OffsetBits)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_code_i  (char_code_i),
    .end_of_text_i(end_of_text_i),
    .accept_i     (accept),
    .res_o        (res),
    .res_cnt_o    (res_cnt)
  );

  stl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (res_cnt),
    .push_data_i(res),
    .pop_i      (out_valid_o && out_ready_i),
    .head_o     (head),
    .space_o    (space),
    .valid_o    (out_valid_o)
  );

  assign in_ready_o     = space;
  assign token_kind_o   = head.kind;
  assign token_start_o  = head.start;
  assign token_length_o = head.length;
  assign is_last_o      = head.last;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for source_token_lexer: directed texts, a long token and random texts.
module testbench;
  import stl_pkg::*;

  localparam int StallLimit  = 1000;
  localparam int RandomBytes = 100;
  localparam int LongRun     = 40;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] char_code;
  logic       end_flag;
  logic       out_valid;
  logic       out_ready;
  logic [4:0] token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic       is_last;

  source_token_lexer uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .char_code_i    (char_code),
    .end_of_text_i  (end_flag),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .token_kind_o   (token_kind),
    .token_start_o  (token_start),
    .token_length_o (token_length),
    .is_last_o      (is_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scanner copy kept by the predictor
  string       kw_word [KwCount] = '{"return", "if", "else", "while", "for", "void", "null"};
  mode_e       scan_mode;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [6:0]  kw_mask;
  bit          dot_flag;
  logic [15:0] offset;
  int          step_tokens;

  res_t        tokens_due [$];
  logic [7:0]  text_q [$];
  bit          idle_on;
  int          mismatches;
  int          bytes_sent;
  int          tokens_seen;
  int          texts_done;
  int          stall_cycles;

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void clear_scanner();
    scan_mode = ModeIdle;
    tok_start = '0;
    tok_len   = '0;
    kw_mask   = 7'h7F;
    dot_flag  = 1'b0;
    offset    = '0;
  endfunction

  function automatic void put_token(kind_e k, logic [15:0] s, logic [15:0] l, bit lst);
    if (step_tokens >= ResMax) return;
    tokens_due.insert(tokens_due.size(), res_t'{kind: k, start: s, length: l, last: lst});
    step_tokens++;
  endfunction

  function automatic void grow();
    if (tok_len != 16'hFFFF) tok_len++;
  endfunction

  function automatic void open_pending(mode_e m);
    scan_mode = m;
    tok_start = offset;
    tok_len   = 16'd1;
  endfunction

  // Drop every keyword whose next letter differs from c
  function automatic void match_letter(logic [7:0] c);
    for (int k = 0; k < KwCount; k++) begin
      if (tok_len >= kw_word[k].len() || kw_word[k][tok_len] != c) kw_mask[k] = 1'b0;
    end
  endfunction

  function automatic void flush_pending();
    kind_e k;
    k = KindUnknown;
    case (scan_mode)
      ModeIdle: return;
      ModeWord: begin
        k = KindSymbol;
        for (int i = 0; i < KwCount; i++) begin
          if (kw_mask[i] && kw_word[i].len() == tok_len) k = kind_e'(i);
        end
      end
      ModeMinus:  k = KindMinus;
      ModeNumber: k = dot_flag ? KindFloat : KindInt;
      ModeBang:   k = KindBang;
      ModeEq:     k = KindSet;
      default:    k = KindUnknown;
    endcase
    put_token(k, tok_start, tok_len, 1'b0);
    scan_mode = ModeIdle;
  endfunction

  function automatic void start_token(logic [7:0] c);
    scan_mode = ModeIdle;
    if (c == " " || (c >= 8'h09 && c <= 8'h0D)) return;
    if (is_alpha(c)) begin
      kw_mask = 7'h7F;
      tok_len = '0;
      match_letter(c);
      open_pending(ModeWord);
      return;
    end
    if (is_num(c)) begin
      dot_flag = 1'b0;
      open_pending(ModeNumber);
      return;
    end
    case (c)
      ChMinus: open_pending(ModeMinus);
      ChQuote: open_pending(ModeQuote1);
      ChBang:  open_pending(ModeBang);
      ChEq:    open_pending(ModeEq);
      "(":     put_token(KindLParen, offset, 16'd1, 1'b0);
      ")":     put_token(KindRParen, offset, 16'd1, 1'b0);
      "{":     put_token(KindLBrace, offset, 16'd1, 1'b0);
      "}":     put_token(KindRBrace, offset, 16'd1, 1'b0);
      ",":     put_token(KindComma, offset, 16'd1, 1'b0);
      ChDot:   put_token(KindDot, offset, 16'd1, 1'b0);
      "+":     put_token(KindPlus, offset, 16'd1, 1'b0);
      ";":     put_token(KindSemi, offset, 16'd1, 1'b0);
      "/":     put_token(KindSlash, offset, 16'd1, 1'b0);
      "*":     put_token(KindStar, offset, 16'd1, 1'b0);
      default: put_token(KindUnknown, offset, 16'd1, 1'b0);
    endcase
  endfunction

  function automatic void continue_token(logic [7:0] c);
    case (scan_mode)
      ModeWord: begin
        if (is_alpha(c)) begin
          match_letter(c);
          grow();
          return;
        end
      end
      ModeMinus: begin
        if (is_num(c)) begin
          scan_mode = ModeNumber;
          dot_flag  = 1'b0;
          grow();
          return;
        end
      end
      ModeNumber: begin
        if (c == ChDot) begin
          // a second dot closes the run as unknown and is rescanned
          if (dot_flag) begin
            put_token(KindUnknown, tok_start, tok_len, 1'b0);
            start_token(c);
            return;
          end
          dot_flag = 1'b1;
          grow();
          return;
        end
        if (is_alpha(c) || is_num(c)) begin
          grow();
          return;
        end
      end
      ModeQuote1: begin
        scan_mode = ModeQuote2;
        grow();
        return;
      end
      ModeQuote2: begin
        if (c == ChQuote) begin
          grow();
          put_token(KindChar, tok_start, tok_len, 1'b0);
          scan_mode = ModeIdle;
          return;
        end
      end
      ModeBang, ModeEq: begin
        if (c == ChEq) begin
          grow();
          put_token(scan_mode == ModeBang ? KindBangEq : KindEq, tok_start, tok_len, 1'b0);
          scan_mode = ModeIdle;
          return;
        end
      end
      default: begin
        start_token(c);
        return;
      end
    endcase
    flush_pending();
    start_token(c);
  endfunction

  // Work out the tokens that one accepted byte causes
  function automatic void scan_byte(logic [7:0] c, bit eot);
    step_tokens = 0;
    if (c != 8'd0) begin
      continue_token(c);
      offset++;
      if (!eot) return;
    end
    flush_pending();
    put_token(KindEnd, offset, 16'd0, 1'b1);
    clear_scanner();
    texts_done++;
  endfunction

  function automatic void flag_error(string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endfunction

  function automatic void check_token();
    res_t want;
    tokens_seen++;
    if (tokens_due.size() == 0) begin
      flag_error($sformatf("unexpected token: kind %0d start %0d len %0d last %0b",
                           token_kind, token_start, token_length, is_last));
      return;
    end
    want = tokens_due.pop_front();
    if (token_kind !== want.kind || token_start !== want.start ||
        token_length !== want.length || is_last !== want.last)
      flag_error($sformatf("token mismatch: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                           want.kind, want.start, want.length, want.last,
                           token_kind, token_start, token_length, is_last));
  endfunction

  // Receiver side, checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= idle_on ? ($urandom_range(0, 99) >= 23) : 1'b1;
      if (out_valid && out_ready) check_token();
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("watchdog: no request moved for %0d cycles", StallLimit);
          $display("testbench: done, errors");
          $finish;
        end
      end
    end
  end

  task automatic send_byte(logic [7:0] c, bit eot);
    while (idle_on && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    end_flag  <= eot;
    do @(posedge clk); while (!in_ready);
    scan_byte(c, eot);
    bytes_sent++;
  endtask

  task automatic send_text(string s, bit zero_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], !zero_end && i == s.len() - 1);
    if (zero_end) send_byte(8'd0, 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tokens_due.size() != 0);
  endtask

  task automatic test_keywords();
    send_text("return(if)else{while}for,void;null", 1'b0);
    send_text("ifx fo Whilee", 1'b1);
    wait_drained();
  endtask

  task automatic test_numbers();
    send_text("-42 7.5+3.1.4 9ab -x", 1'b1);
    send_text("-", 1'b0);
    wait_drained();
  endtask

  task automatic test_quotes();
    send_text("'a' 'bc ''''", 1'b0);
    send_text("'z", 1'b1);
    wait_drained();
  endtask

  task automatic test_operators();
    send_text("!=!x==/=*.!", 1'b0);
    send_text("=", 1'b0);
    wait_drained();
  endtask

  task automatic test_byte_extremes();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h0B, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'd0, 1'b1);
    send_byte(8'd0, 1'b0);
    send_byte(8'h09, 1'b1);
    wait_drained();
  endtask

  // Run one long word back to back with both sides always ready
  task automatic test_long_token();
    idle_on = 1'b0;
    for (int i = 0; i < LongRun; i++) send_byte("a", 1'b0);
    send_byte(";", 1'b1);
    wait_drained();
    idle_on = 1'b1;
  endtask

  function automatic void add_byte(logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] any_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  function automatic void add_digits();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) add_byte(8'($urandom_range("0", "9")));
  endfunction

  function automatic void add_piece();
    string      delims;
    logic [7:0] blanks [6];
    int         k;
    delims = "(){},.+;/*-";
    blanks = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    case ($urandom_range(0, 9))
      0: add_text(kw_word[$urandom_range(0, KwCount - 1)]);
      1: begin
        k = $urandom_range(0, KwCount - 1);
        if ($urandom_range(0, 1)) begin
          add_text(kw_word[k].substr(0, $urandom_range(0, kw_word[k].len() - 1)));
          if ($urandom_range(0, 1)) add_byte(any_letter());
        end else begin
          repeat ($urandom_range(1, 8)) add_byte(any_letter());
        end
      end
      2: begin
        if ($urandom_range(0, 2) == 0) add_byte(ChMinus);
        add_digits();
        if ($urandom_range(0, 1)) begin
          add_byte(ChDot);
          add_digits();
        end
        if ($urandom_range(0, 5) == 0) begin
          add_byte(ChDot);
          add_digits();
        end
        if ($urandom_range(0, 4) == 0) add_byte(any_letter());
      end
      3: begin
        add_byte(ChQuote);
        add_byte(8'($urandom_range(1, 255)));
        add_byte($urandom_range(0, 4) ? ChQuote : 8'($urandom_range(1, 255)));
      end
      4: add_byte(delims[$urandom_range(0, delims.len() - 1)]);
      5: begin
        add_byte($urandom_range(0, 1) ? ChBang : ChEq);
        if ($urandom_range(0, 2)) add_byte(ChEq);
      end
      6: add_byte(blanks[$urandom_range(0, 5)]);
      7: add_byte(8'($urandom_range(1, 255)));
      default: add_byte(" ");
    endcase
  endfunction

  task automatic test_random();
    int  first;
    bit  zero_end;
    first = bytes_sent;
    while (bytes_sent - first < RandomBytes) begin
      // hold a stretch in the middle with both sides always ready
      idle_on = (bytes_sent - first < 30) || (bytes_sent - first >= 70);
      text_q.delete();
      repeat ($urandom_range(0, 12)) add_piece();
      zero_end = (text_q.size() == 0) || $urandom_range(0, 1);
      for (int i = 0; i < text_q.size(); i++)
        send_byte(text_q[i], !zero_end && i == text_q.size() - 1);
      if (zero_end) send_byte(8'd0, 1'($urandom_range(0, 1)));
    end
    idle_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    char_code    = 8'd0;
    end_flag     = 1'b0;
    out_ready    = 1'b0;
    idle_on      = 1'b1;
    mismatches   = 0;
    bytes_sent   = 0;
    tokens_seen  = 0;
    texts_done   = 0;
    stall_cycles = 0;
    clear_scanner();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_keywords();
    test_numbers();
    test_quotes();
    test_operators();
    test_byte_extremes();
    test_long_token();
    test_random();

    repeat (8) @(posedge clk);
    if (tokens_due.size() != 0)
      flag_error($sformatf("%0d tokens never arrived", tokens_due.size()));
    $display("summary: %0d bytes in %0d texts scanned, %0d tokens checked",
             bytes_sent, texts_done, tokens_seen);
    $display("summary: keywords, numbers, quotes, operators, odd bytes, long token, random texts");
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
